>>> sv/swaq_pkg.sv
// ----------------------------------------------------------------------------
// swaq_pkg
// shared types and constants of the sorted wake-up alarm queue
// ----------------------------------------------------------------------------
`default_nettype none

package swaq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_W      = 63;
    localparam int WAKE_W      = 64;
    localparam int ID_W        = 8;
    localparam int LEN_W       = 32;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [PADDR_W-3:0] REG_IDLE_ID = '0;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WOKEN  = 1'b1;

    localparam logic FUNC_SLEEP = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef struct packed {
        logic load_sleep;
        logic tick_inc;
        logic sleep_done;
        logic pop;
    } swaq_cmd_t;

    typedef struct packed {
        logic head_due;
        logic next_due;
    } swaq_sts_t;

endpackage

`default_nettype wire

>>> sv/swaq_regs.sv
// ----------------------------------------------------------------------------
// swaq_regs
// apb register file holding the idle thread id
// ----------------------------------------------------------------------------
`default_nettype none

module swaq_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [swaq_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [swaq_pkg::PDATA_W-1:0]      pwdata,
    output logic      [swaq_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready,
    output logic      [swaq_pkg::ID_W-1:0]         idle_id
);

    logic [swaq_pkg::ID_W-1:0] idle_id_reg;
    logic                      sel_idle;

    assign sel_idle = (paddr[swaq_pkg::PADDR_W-1:2] == swaq_pkg::REG_IDLE_ID);
    assign pready   = 1'b1;
    assign idle_id  = idle_id_reg;

    always_comb
    begin
        prdata = '0;
        if (sel_idle)
        begin
            prdata[swaq_pkg::ID_W-1:0] = idle_id_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_id_reg <= '0;
        end
        else if (psel && penable && pwrite && sel_idle)
        begin
            idle_id_reg <= pwdata[swaq_pkg::ID_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/swaq_ctrl.sv
// ----------------------------------------------------------------------------
// swaq_ctrl
// request sequencer: sleep insert and tick pop loop
// ----------------------------------------------------------------------------
`default_nettype none

module swaq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                func,
    output logic                     busy,
    output swaq_pkg::swaq_cmd_t      cmd,
    input  wire swaq_pkg::swaq_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLEEP,
        S_POP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (func == swaq_pkg::FUNC_TICK)
                    begin
                        cmd.tick_inc = 1'b1;
                        state_next   = S_POP;
                    end
                    else
                    begin
                        cmd.load_sleep = 1'b1;
                        state_next     = S_SLEEP;
                    end
                end
            end
            S_SLEEP:
            begin
                cmd.sleep_done = 1'b1;
                state_next     = S_IDLE;
            end
            S_POP:
            begin
                if (sts.head_due)
                begin
                    cmd.pop = 1'b1;
                end
                if (!(sts.head_due && sts.next_due))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/swaq_dp.sv
// ----------------------------------------------------------------------------
// swaq_dp
// tick counter, sorted sleeper queue and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module swaq_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire swaq_pkg::swaq_cmd_t                 cmd,
    output swaq_pkg::swaq_sts_t                      sts,
    input  wire logic [swaq_pkg::ID_W-1:0]           idle_id,
    input  wire logic [swaq_pkg::ID_W-1:0]           thread_id,
    input  wire logic signed [swaq_pkg::LEN_W-1:0]   sleep_ticks,
    output logic                                     result_valid,
    output logic                                     kind,
    output logic      [1:0]                          status,
    output logic      [swaq_pkg::ID_W-1:0]           woken_id,
    output logic                                     last,
    output logic      [swaq_pkg::TICK_W-1:0]         now_ticks
);

    localparam int D = swaq_pkg::QUEUE_DEPTH;

    logic [swaq_pkg::TICK_W-1:0] tick_reg;
    logic [swaq_pkg::OCC_W-1:0]  occ_reg;
    logic [swaq_pkg::WAKE_W-1:0] wake_q_reg [D];
    logic [swaq_pkg::ID_W-1:0]   id_q_reg   [D];

    logic [swaq_pkg::WAKE_W-1:0] new_wake_reg;
    logic [swaq_pkg::ID_W-1:0]   new_id_reg;
    logic                        ignored_reg;

    logic                        result_valid_reg;
    logic                        kind_reg;
    logic [1:0]                  status_reg;
    logic [swaq_pkg::ID_W-1:0]   woken_id_reg;
    logic                        last_reg;
    logic [swaq_pkg::TICK_W-1:0] now_ticks_reg;

    logic [swaq_pkg::WAKE_W-1:0] tick_ext;
    logic                        full;
    logic                        do_insert;
    logic [1:0]                  sleep_status;
    logic [D-1:0]                le;
    logic [D-1:0]                prev_le;
    logic                        positive;

    assign tick_ext  = {1'b0, tick_reg};
    assign full      = (occ_reg == swaq_pkg::OCC_W'(D));
    assign positive  = !sleep_ticks[swaq_pkg::LEN_W-1] && (sleep_ticks != '0);
    assign do_insert = cmd.sleep_done && !ignored_reg && !full;

    always_comb
    begin
        if (ignored_reg)
        begin
            sleep_status = swaq_pkg::ST_IGNORED;
        end
        else if (full)
        begin
            sleep_status = swaq_pkg::ST_FULL;
        end
        else
        begin
            sleep_status = swaq_pkg::ST_ACCEPTED;
        end
    end

    assign sts.head_due = (occ_reg != '0) && (wake_q_reg[0] <= tick_ext);
    assign sts.next_due = (occ_reg > swaq_pkg::OCC_W'(1)) && (wake_q_reg[1] <= tick_ext);

    // insertion point: valid entries not later than the new wake time form a prefix
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            le[i] = (swaq_pkg::OCC_W'(i) < occ_reg) && (wake_q_reg[i] <= new_wake_reg);
        end
        prev_le[0] = 1'b1;
        for (int i = 1; i < D; i++)
        begin
            prev_le[i] = le[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg         <= '0;
            occ_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + swaq_pkg::TICK_W'(1);
            end
            if (do_insert)
            begin
                occ_reg <= occ_reg + swaq_pkg::OCC_W'(1);
            end
            else if (cmd.pop)
            begin
                occ_reg <= occ_reg - swaq_pkg::OCC_W'(1);
            end
            result_valid_reg <= cmd.sleep_done || cmd.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sleep)
        begin
            new_wake_reg <= tick_ext
                            + {{(swaq_pkg::WAKE_W-swaq_pkg::LEN_W+1){1'b0}},
                               sleep_ticks[swaq_pkg::LEN_W-2:0]};
            new_id_reg   <= thread_id;
            ignored_reg  <= !positive || (thread_id == idle_id);
        end

        if (do_insert)
        begin
            if (!le[0])
            begin
                wake_q_reg[0] <= new_wake_reg;
                id_q_reg[0]   <= new_id_reg;
            end
            for (int i = 1; i < D; i++)
            begin
                if (!le[i])
                begin
                    if (prev_le[i])
                    begin
                        wake_q_reg[i] <= new_wake_reg;
                        id_q_reg[i]   <= new_id_reg;
                    end
                    else
                    begin
                        wake_q_reg[i] <= wake_q_reg[i-1];
                        id_q_reg[i]   <= id_q_reg[i-1];
                    end
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < D - 1; i++)
            begin
                wake_q_reg[i] <= wake_q_reg[i+1];
                id_q_reg[i]   <= id_q_reg[i+1];
            end
        end

        if (cmd.sleep_done)
        begin
            kind_reg      <= swaq_pkg::KIND_STATUS;
            status_reg    <= sleep_status;
            woken_id_reg  <= '0;
            last_reg      <= 1'b1;
            now_ticks_reg <= tick_reg;
        end
        else if (cmd.pop)
        begin
            kind_reg      <= swaq_pkg::KIND_WOKEN;
            status_reg    <= swaq_pkg::ST_ACCEPTED;
            woken_id_reg  <= id_q_reg[0];
            last_reg      <= !sts.next_due;
            now_ticks_reg <= tick_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign woken_id     = woken_id_reg;
    assign last         = last_reg;
    assign now_ticks    = now_ticks_reg;

endmodule

`default_nettype wire

>>> sv/sorted_wakeup_alarm_queue.sv
// ----------------------------------------------------------------------------
// sorted_wakeup_alarm_queue
// tick counter with a wake-time sorted queue of sleeping threads
// ----------------------------------------------------------------------------
// requests enter on start while busy is low; func selects sleep or tick
// a sleep request keeps busy high for one cycle and gives one status
// result, registered while busy is high
// a tick bumps the counter, then pops one due sleeper per cycle from the
// queue head; each pop gives one woken result, the final one with last set
// a tick keeps busy high until its last due sleeper is popped (for one
// cycle when nothing is due) and each of its results is registered from its pop
// results appear on result_valid for exactly one cycle; the receiver has
// no way to stall, so nothing is held back
// idle_thread_id sits at apb address 0; write it only while busy is low
// reset clears the counter, empties the queue and sets idle_thread_id to 0
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_wakeup_alarm_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              func,
    input  wire logic [swaq_pkg::ID_W-1:0]         thread_id,
    input  wire logic signed [swaq_pkg::LEN_W-1:0] sleep_ticks,
    output logic                                   result_valid,
    output logic                                   kind,
    output logic      [1:0]                        status,
    output logic      [swaq_pkg::ID_W-1:0]         woken_id,
    output logic                                   last,
    output logic      [swaq_pkg::TICK_W-1:0]       now_ticks,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [swaq_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [swaq_pkg::PDATA_W-1:0]      pwdata,
    output logic      [swaq_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready
);

    swaq_pkg::swaq_cmd_t        cmd;
    swaq_pkg::swaq_sts_t        sts;
    logic [swaq_pkg::ID_W-1:0]  idle_id;

    swaq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .idle_id (idle_id)
    );

    swaq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    swaq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .idle_id      (idle_id),
        .thread_id    (thread_id),
        .sleep_ticks  (sleep_ticks),
        .result_valid (result_valid),
        .kind         (kind),
        .status       (status),
        .woken_id     (woken_id),
        .last         (last),
        .now_ticks    (now_ticks)
    );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for the sorted wake-up alarm queue
// ----------------------------------------------------------------------------
// requests are queued per phase by the stimulus process and sent by a
// negedge driver with random gaps
// a posedge monitor keeps its own copy of the tick counter and the sleeper
// queue, predicts the status and woken-thread results of each taken
// request and checks every strobed result field by field
// the idle thread id is rewritten between phases over apb and read back
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = swaq_pkg::QUEUE_DEPTH;
    localparam int TICK_W      = swaq_pkg::TICK_W;
    localparam int WAKE_W      = swaq_pkg::WAKE_W;
    localparam int ID_W        = swaq_pkg::ID_W;
    localparam int LEN_W       = swaq_pkg::LEN_W;
    localparam int PADDR_W     = swaq_pkg::PADDR_W;
    localparam int PDATA_W     = swaq_pkg::PDATA_W;

    localparam logic [1:0] ST_ACCEPTED = swaq_pkg::ST_ACCEPTED;
    localparam logic [1:0] ST_IGNORED  = swaq_pkg::ST_IGNORED;
    localparam logic [1:0] ST_FULL     = swaq_pkg::ST_FULL;
    localparam logic KIND_STATUS = swaq_pkg::KIND_STATUS;
    localparam logic KIND_WOKEN  = swaq_pkg::KIND_WOKEN;
    localparam logic FUNC_SLEEP  = swaq_pkg::FUNC_SLEEP;
    localparam logic FUNC_TICK   = swaq_pkg::FUNC_TICK;

    localparam int MAX_WAKE = 16;
    localparam logic [PADDR_W-1:0] IDLE_ID_ADDR = {swaq_pkg::REG_IDLE_ID, 2'b00};

    typedef struct {
        logic                    func;
        logic [ID_W-1:0]         thread_id;
        logic signed [LEN_W-1:0] sleep_ticks;
    } alarm_req_t;

    typedef struct {
        logic              kind;
        logic [1:0]        status;
        logic [ID_W-1:0]   woken_id;
        logic              last;
        logic [TICK_W-1:0] now_ticks;
    } wake_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic func = FUNC_SLEEP;
    logic [ID_W-1:0] thread_id = '0;
    logic signed [LEN_W-1:0] sleep_ticks = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;

    logic busy;
    logic result_valid;
    logic kind;
    logic [1:0] status;
    logic [ID_W-1:0] woken_id;
    logic last;
    logic [TICK_W-1:0] now_ticks;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    alarm_req_t pending_reqs[$];
    wake_event_t due_results[$];

    // predictor state
    logic [TICK_W-1:0] tick_model = '0;
    logic [WAKE_W-1:0] wake_model [QUEUE_DEPTH];
    logic [ID_W-1:0] sleeper_model [QUEUE_DEPTH];
    int occ_model = 0;
    logic [ID_W-1:0] idle_model = '0;

    logic [ID_W-1:0] cur_idle = '0;
    bit req_taken = 1'b0;
    int gap_left = 0;
    int calm_left = 0;
    int err_count = 0;

    sorted_wakeup_alarm_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .thread_id    (thread_id),
        .sleep_ticks  (sleep_ticks),
        .result_valid (result_valid),
        .kind         (kind),
        .status       (status),
        .woken_id     (woken_id),
        .last         (last),
        .now_ticks    (now_ticks),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic advance_alarm_model(input logic f, input logic [ID_W-1:0] tid,
                                       input logic signed [LEN_W-1:0] len);
        wake_event_t ev;
        logic [WAKE_W-1:0] wake;
        int pos;
        int n;
        ev.kind = KIND_STATUS;
        ev.status = ST_ACCEPTED;
        ev.woken_id = '0;
        ev.last = 1'b1;
        if (f == FUNC_SLEEP)
        begin
            if (len <= 0 || tid == idle_model)
            begin
                ev.status = ST_IGNORED;
            end
            else if (occ_model >= QUEUE_DEPTH)
            begin
                ev.status = ST_FULL;
            end
            else
            begin
                wake = {1'b0, tick_model} + {32'b0, len};
                pos = 0;
                while (pos < occ_model && wake_model[pos] <= wake)
                begin
                    pos++;
                end
                for (int i = occ_model; i > pos; i--)
                begin
                    wake_model[i] = wake_model[i-1];
                    sleeper_model[i] = sleeper_model[i-1];
                end
                wake_model[pos] = wake;
                sleeper_model[pos] = tid;
                occ_model++;
            end
            ev.now_ticks = tick_model;
            due_results.push_back(ev);
        end
        else
        begin
            tick_model = tick_model + 1'b1;
            n = 0;
            while (n < occ_model && n < MAX_WAKE && wake_model[n] <= {1'b0, tick_model})
            begin
                n++;
            end
            for (int k = 0; k < n; k++)
            begin
                ev.kind = KIND_WOKEN;
                ev.status = ST_ACCEPTED;
                ev.woken_id = sleeper_model[k];
                ev.last = (k == n - 1);
                ev.now_ticks = tick_model;
                due_results.push_back(ev);
            end
            for (int i = n; i < occ_model; i++)
            begin
                wake_model[i-n] = wake_model[i];
                sleeper_model[i-n] = sleeper_model[i];
            end
            occ_model -= n;
        end
    endtask

    task automatic check_result();
        wake_event_t want;
        if (due_results.size() == 0)
        begin
            flag_mismatch("result with nothing due");
        end
        else
        begin
            want = due_results.pop_front();
            check_field("kind", 64'(kind), 64'(want.kind));
            check_field("status", 64'(status), 64'(want.status));
            check_field("woken_id", 64'(woken_id), 64'(want.woken_id));
            check_field("last", 64'(last), 64'(want.last));
            check_field("now_ticks", 64'(now_ticks), 64'(want.now_ticks));
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        alarm_req_t nxt;
        if (start && !req_taken)
        begin
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            nxt = pending_reqs.pop_front();
            func <= nxt.func;
            thread_id <= nxt.thread_id;
            sleep_ticks <= nxt.sleep_ticks;
            start <= 1'b1;
            if (calm_left > 0)
            begin
                calm_left <= calm_left - 1;
                gap_left <= 0;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                calm_left <= 24;
                gap_left <= 0;
            end
            else
            begin
                gap_left <= $urandom_range(0, 8);
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                check_result();
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    idle_model = pwdata[ID_W-1:0];
                end
                else
                begin
                    check_field("prdata", 64'(prdata), {56'b0, idle_model});
                end
            end
            req_taken = start && !busy;
            if (req_taken)
            begin
                advance_alarm_model(func, thread_id, sleep_ticks);
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= IDLE_ID_ADDR;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_idle(input logic [ID_W-1:0] id);
        apb_access(1'b1, {24'b0, id});
        apb_access(1'b0, '0);
        cur_idle = id;
    endtask

    task automatic push_req(input logic f, input logic [ID_W-1:0] tid,
                            input logic signed [LEN_W-1:0] len);
        alarm_req_t r;
        r.func = f;
        r.thread_id = tid;
        r.sleep_ticks = len;
        pending_reqs.push_back(r);
    endtask

    task automatic push_tick();
        push_req(FUNC_TICK, ID_W'($urandom_range(0, 255)), $urandom);
    endtask

    task automatic wait_quiet();
        while (pending_reqs.size() > 0 || start || busy)
        begin
            @(posedge clk);
        end
        repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (due_results.size() > 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived", due_results.size()));
            due_results.delete();
        end
    endtask

    task automatic queue_random_traffic(input int n_items);
        int target;
        int pick;
        int k;
        target = pending_reqs.size() + n_items;
        while (pending_reqs.size() < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // one to five sleepers, then one to ten ticks that may wake some of them
                k = $urandom_range(1, 5);
                for (int i = 0; i < k; i++)
                begin
                    push_req(FUNC_SLEEP, ID_W'($urandom_range(0, 255)),
                             $urandom_range(1, 12));
                end
                k = $urandom_range(1, 10);
                for (int i = 0; i < k; i++)
                begin
                    push_tick();
                end
            end
            else if (pick < 72)
            begin
                // burst past the queue depth, then drain
                for (int i = 0; i < QUEUE_DEPTH + 2; i++)
                begin
                    push_req(FUNC_SLEEP, ID_W'($urandom_range(0, 255)),
                             $urandom_range(1, 4));
                end
                for (int i = 0; i < 6; i++)
                begin
                    push_tick();
                end
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: push_tick();
                    1: push_req(FUNC_SLEEP, ID_W'($urandom_range(0, 255)),
                                $urandom | 32'h8000_0000);
                    2: push_req(FUNC_SLEEP, ID_W'($urandom_range(0, 255)), 0);
                    3: push_req(FUNC_SLEEP, cur_idle, $urandom_range(1, 12));
                    default: push_req(FUNC_SLEEP, ID_W'($urandom_range(0, 255)),
                                      $urandom_range(1, 60));
                endcase
            end
        end
        while (pending_reqs.size() > target)
        begin
            void'(pending_reqs.pop_back());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_idle(8'd0);
        push_req(FUNC_SLEEP, 8'd5, 0);
        push_req(FUNC_SLEEP, 8'd6, -1);
        push_req(FUNC_SLEEP, 8'd7, 32'sh8000_0000);
        push_req(FUNC_SLEEP, 8'd0, 3);
        push_req(FUNC_SLEEP, 8'd1, 1);
        push_req(FUNC_SLEEP, 8'd2, 3);
        push_req(FUNC_SLEEP, 8'd3, 3);
        push_req(FUNC_SLEEP, 8'd4, 2);
        push_req(FUNC_SLEEP, 8'd2, 3);
        push_req(FUNC_TICK, 8'd0, 0);
        push_req(FUNC_TICK, 8'hFF, -1);
        push_req(FUNC_TICK, 8'hAA, 32'sh7FFF_FFFF);
        push_req(FUNC_TICK, 8'h55, 32'sh8000_0000);
        push_req(FUNC_SLEEP, 8'h80, 1);
        push_req(FUNC_SLEEP, 8'h81, 1);
        push_req(FUNC_SLEEP, 8'hFE, 2);
        push_req(FUNC_TICK, 8'h00, 0);
        push_req(FUNC_TICK, 8'h00, 0);
        wait_quiet();

        set_idle(8'd255);
        queue_random_traffic(80);
        wait_quiet();

        set_idle(ID_W'($urandom_range(1, 254)));
        queue_random_traffic(80);
        wait_quiet();

        set_idle(8'd0);
        queue_random_traffic(80);
        // a sleeper that can never wake stays at the tail to the end
        push_req(FUNC_SLEEP, 8'd255, 32'sh7FFF_FFFF);
        push_req(FUNC_SLEEP, 8'd9, 1);
        push_tick();
        wait_quiet();

        if (err_count == 0)
        begin
            $display("sorted_wakeup_alarm_queue: match");
        end
        else
        begin
            $display("sorted_wakeup_alarm_queue: mismatch");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("sorted_wakeup_alarm_queue: mismatch");
        $finish;
    end

endmodule

>>> files.f
sv/swaq_pkg.sv
sv/swaq_regs.sv
sv/swaq_ctrl.sv
sv/swaq_dp.sv
sv/sorted_wakeup_alarm_queue.sv
sim/tb_top.sv
